/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

/* rtl/imm_pkg.sv */
// ----------------------------------------------------------------------------
// imm_pkg
// types, sizes and codes shared by the matrix multiply block
// ----------------------------------------------------------------------------
package imm_pkg;

    localparam int DIM    = 8;
    localparam int IDX_W  = $clog2(DIM);
    localparam int CNT_W  = $clog2(DIM + 1);
    localparam int ADDR_W = $clog2(DIM * DIM);
    localparam int DEPTH  = DIM * DIM;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int SUM_W  = 36;
    localparam int DIM_W  = 4;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // operation codes
    localparam logic [1:0] OP_WR_A = 2'd0;
    localparam logic [1:0] OP_WR_B = 2'd1;
    localparam logic [1:0] OP_MUL  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_INNER  = 2'd1;
    localparam logic [1:0] REG_COLS_B = 2'd2;

    typedef struct packed {
        logic [1:0]               operation;
        logic [2:0]               row_index;
        logic [2:0]               col_index;
        logic signed [ELEM_W-1:0] element_value;
    } t_item;

    typedef struct packed {
        logic [2:0]              out_row;
        logic [2:0]              out_col;
        logic signed [SUM_W-1:0] product_sum;
        logic                    last_result;
    } t_result;

    // clamped dimensions
    typedef struct packed {
        logic [CNT_W-1:0] nr;
        logic [CNT_W-1:0] nk;
        logic [CNT_W-1:0] nc;
    } t_dims;

    // controller to datapath
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             issue;
        logic             first;
        logic             last;
        logic             zero;
        logic             fin;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } t_dp_cmd;

endpackage

/* rtl/imm_ctrl.sv */
// ----------------------------------------------------------------------------
// imm_ctrl
// sequencer: store writes, and the row / column / inner index walk
// ----------------------------------------------------------------------------
module imm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  imm_pkg::t_item    i_item,
    input  imm_pkg::t_dims    i_dims,
    output logic              o_busy,
    output imm_pkg::t_dp_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic                      r_state, n_state;
    logic [imm_pkg::IDX_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic                      accept, in_range, k_last, j_last, i_last;

    assign o_busy   = (r_state == S_RUN);
    assign accept   = i_start && (r_state == S_IDLE);
    assign in_range = (int'(i_item.row_index) < imm_pkg::DIM) &&
                      (int'(i_item.col_index) < imm_pkg::DIM);

    assign k_last = (i_dims.nk == '0) ||
                    (imm_pkg::CNT_W'(r_k) + 1'b1 == i_dims.nk);
    assign j_last = (imm_pkg::CNT_W'(r_j) + 1'b1 == i_dims.nc);
    assign i_last = (imm_pkg::CNT_W'(r_i) + 1'b1 == i_dims.nr);

    always_comb begin
        o_cmd       = '0;
        o_cmd.wr_a  = accept && in_range && (i_item.operation == imm_pkg::OP_WR_A);
        o_cmd.wr_b  = accept && in_range && (i_item.operation == imm_pkg::OP_WR_B);
        o_cmd.issue = (r_state == S_RUN);
        o_cmd.first = (r_k == '0);
        o_cmd.last  = k_last;
        o_cmd.zero  = (i_dims.nk == '0);
        o_cmd.fin   = k_last && j_last && i_last;
        o_cmd.i     = r_i;
        o_cmd.j     = r_j;
        o_cmd.k     = r_k;
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_item.operation == imm_pkg::OP_MUL) &&
                    (i_dims.nr != '0) && (i_dims.nc != '0)) begin
                    n_state = S_RUN;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            S_RUN: begin
                if (k_last) begin
                    n_k = '0;
                    if (j_last) begin
                        n_j = '0;
                        if (i_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

endmodule

/* rtl/imm_dp.sv */
// ----------------------------------------------------------------------------
// imm_dp
// element stores, read stage, multiplier stage and accumulator stage
// ----------------------------------------------------------------------------
module imm_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  imm_pkg::t_item    i_item,
    input  imm_pkg::t_dp_cmd  i_cmd,
    output logic              o_result_valid,
    output imm_pkg::t_result  o_result
);

    logic signed [imm_pkg::ELEM_W-1:0] mem_a [imm_pkg::DEPTH];
    logic signed [imm_pkg::ELEM_W-1:0] mem_b [imm_pkg::DEPTH];

    logic [imm_pkg::ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

    // read stage
    logic                              r_v1, r_first1, r_last1, r_zero1, r_fin1;
    logic [imm_pkg::IDX_W-1:0]         r_row1, r_col1;
    logic signed [imm_pkg::ELEM_W-1:0] r_a1, r_b1;
    logic signed [imm_pkg::PROD_W-1:0] prod1;
    // multiply stage
    logic                              r_v2, r_first2, r_last2, r_fin2;
    logic [imm_pkg::IDX_W-1:0]         r_row2, r_col2;
    logic signed [imm_pkg::PROD_W-1:0] r_prod2;
    // accumulate stage
    logic                              r_out_valid, r_fin3;
    logic [imm_pkg::IDX_W-1:0]         r_row3, r_col3;
    logic signed [imm_pkg::SUM_W-1:0]  r_acc, prod_ext;

    assign wr_addr   = imm_pkg::ADDR_W'(int'(i_item.row_index) * imm_pkg::DIM +
                                        int'(i_item.col_index));
    assign rd_addr_a = imm_pkg::ADDR_W'(int'(i_cmd.i) * imm_pkg::DIM + int'(i_cmd.k));
    assign rd_addr_b = imm_pkg::ADDR_W'(int'(i_cmd.k) * imm_pkg::DIM + int'(i_cmd.j));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            mem_a[wr_addr] <= i_item.element_value;
        end
        if (i_cmd.issue) begin
            r_a1 <= mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) begin
            mem_b[wr_addr] <= i_item.element_value;
        end
        if (i_cmd.issue) begin
            r_b1 <= mem_b[rd_addr_b];
        end
    end

    // signed 16 x 16 product, kept signed on its own
    assign prod1    = r_a1 * r_b1;
    assign prod_ext = imm_pkg::SUM_W'(r_prod2);

    // payload pipeline
    always_ff @(posedge i_clk) begin
        r_first1 <= i_cmd.first;
        r_last1  <= i_cmd.last;
        r_zero1  <= i_cmd.zero;
        r_fin1   <= i_cmd.fin;
        r_row1   <= i_cmd.i;
        r_col1   <= i_cmd.j;

        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_fin2   <= r_fin1;
        r_row2   <= r_row1;
        r_col2   <= r_col1;
        r_prod2  <= r_zero1 ? '0 : prod1;

        if (r_v2) begin
            r_acc  <= r_first2 ? prod_ext : r_acc + prod_ext;
            r_fin3 <= r_fin2;
            r_row3 <= r_row2;
            r_col3 <= r_col2;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1        <= i_cmd.issue;
            r_v2        <= r_v1;
            r_out_valid <= r_v2 && r_last2;
        end
    end

    assign o_result_valid       = r_out_valid;
    assign o_result.out_row     = 3'(r_row3);
    assign o_result.out_col     = 3'(r_col3);
    assign o_result.product_sum = r_acc;
    assign o_result.last_result = r_fin3;

endmodule

/* rtl/integer_matrix_multiply.sv */
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// loads two signed matrices into on-chip stores and streams their product
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                     word
// -------   ---------  ----------------------------  -----------------------
// command   in         start high, busy low          i_item (t_item)
// result    out        o_result_valid, one cycle     o_result (t_result)
// config    in         psel & penable & pwrite       pwdata, paddr[3:2]
//
// a store write leaves busy low, so writes go back to back
// a multiply holds busy through its rows * cols * max(inner, 1) inner steps, one
// step per cycle through the single read port of each store and one multiplier
// each product element leaves through the read, multiply and accumulate registers after its last inner step
// reset is synchronous and clears the dimension registers to eight and the
// control state; the stores keep no reset and must be written before use
// results cannot be stalled: each stands on the ports for one cycle only
//
`include "assert_macros.svh"

module integer_matrix_multiply (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  imm_pkg::t_item                i_item,
    // result channel
    output logic                          o_result_valid,
    output imm_pkg::t_result              o_result,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [imm_pkg::PADDR_W-1:0]   paddr,
    input  logic [imm_pkg::PDATA_W-1:0]   pwdata,
    output logic [imm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    // dimension registers, raw as written
    logic [imm_pkg::DIM_W-1:0] r_rows_a, r_inner, r_cols_b;
    logic                      cfg_wr;
    logic [1:0]                reg_idx;
    imm_pkg::t_dims            dims;
    imm_pkg::t_dp_cmd          cmd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= imm_pkg::DIM_W'(8);
            r_inner  <= imm_pkg::DIM_W'(8);
            r_cols_b <= imm_pkg::DIM_W'(8);
        end else if (cfg_wr) begin
            case (reg_idx)
                imm_pkg::REG_ROWS_A: r_rows_a <= pwdata[imm_pkg::DIM_W-1:0];
                imm_pkg::REG_INNER:  r_inner  <= pwdata[imm_pkg::DIM_W-1:0];
                imm_pkg::REG_COLS_B: r_cols_b <= pwdata[imm_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            imm_pkg::REG_ROWS_A: prdata = imm_pkg::PDATA_W'(r_rows_a);
            imm_pkg::REG_INNER:  prdata = imm_pkg::PDATA_W'(r_inner);
            imm_pkg::REG_COLS_B: prdata = imm_pkg::PDATA_W'(r_cols_b);
            default:             prdata = '0;
        endcase
    end

    // a register above the store size counts as the full size
    always_comb begin
        dims.nr = (int'(r_rows_a) > imm_pkg::DIM) ? imm_pkg::CNT_W'(imm_pkg::DIM)
                                                  : imm_pkg::CNT_W'(r_rows_a);
        dims.nk = (int'(r_inner) > imm_pkg::DIM)  ? imm_pkg::CNT_W'(imm_pkg::DIM)
                                                  : imm_pkg::CNT_W'(r_inner);
        dims.nc = (int'(r_cols_b) > imm_pkg::DIM) ? imm_pkg::CNT_W'(imm_pkg::DIM)
                                                  : imm_pkg::CNT_W'(r_cols_b);
    end

    // index walk and store write enables
    imm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_dims  (dims),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // stores, multiplier and accumulator
    imm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // a result follows an inner step issued under busy, via the read, multiply and accumulate registers
    `ASSERT_SAME(a_result_after_run, o_result_valid, $past(busy, 3))

    // the final element of a run is never followed at once by another
    `ASSERT_NEXT(a_last_gap, o_result_valid && o_result.last_result, !o_result_valid)

    // a multiply with a non-empty product starts a run
    `ASSERT_NEXT(a_mul_starts,
        start && !busy && (i_item.operation == imm_pkg::OP_MUL) &&
        (dims.nr != '0) && (dims.nc != '0), busy)

endmodule
